[sv/lcdws_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdws_pkg
// Shared types, codes and the character map of the LCD write sequencer.
// ----------------------------------------------------------------------------
package lcdws_pkg;

  typedef enum logic [1:0] {
    KIND_CMD    = 2'd0,
    KIND_CHAR   = 2'd1,
    KIND_CURSOR = 2'd2,
    KIND_NONE   = 2'd3
  } lcdws_kind_e;

  localparam logic [7:0] CharSpace   = 8'h20;
  localparam logic [7:0] CharNewline = 8'h0A;
  localparam logic [7:0] CharBlock   = 8'hFF;

  // Decoded request: keep flag, two-strobe flag, register select, first strobe bus, second strobe bus.
  typedef struct packed {
    logic       keep;
    logic       two;
    logic       rs;
    logic [7:0] bus0;
    logic [7:0] bus1;
  } lcdws_req_t;

  function automatic logic [7:0] map_char(input logic [7:0] c);
    logic [7:0] r;
    r = CharSpace;
    if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
        (c >= 8'h20 && c <= 8'h3F)) begin
      r = c;
    end else if (c == CharNewline) begin
      r = CharBlock;
    end
    return r;
  endfunction

endpackage

[sv/lcdws_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdws_req_if / lcdws_strobe_if
// Valid/ready channels for requests and enable strobes.
// ----------------------------------------------------------------------------
interface lcdws_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] value;
  logic [3:0] column;
  logic       row;

  modport source (output valid, kind, value, column, row, input ready);
  modport sink (input valid, kind, value, column, row, output ready);
endinterface

interface lcdws_strobe_if;
  logic       valid;
  logic       ready;
  logic       reg_select;
  logic [7:0] bus;
  logic       last;

  modport source (output valid, reg_select, bus, last, input ready);
  modport sink (input valid, reg_select, bus, last, output ready);
endinterface

[sv/lcdws_decode.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdws_decode
// Turns one request into register select, bus bytes and strobe count.
// ----------------------------------------------------------------------------
module lcdws_decode
  import lcdws_pkg::*;
(
  input  logic [1:0] kind_i,
  input  logic [7:0] value_i,
  input  logic [3:0] column_i,
  input  logic       row_i,
  input  logic       bus_is_8bit_i,
  output lcdws_req_t req_o
);

  logic [7:0] byte_w;

  always_comb begin
    req_o  = '0;
    byte_w = map_char(value_i);
    case (lcdws_kind_e'(kind_i))
      KIND_CMD: begin
        req_o.keep = 1'b1;
        req_o.rs   = 1'b0;
        req_o.bus0 = bus_is_8bit_i ? value_i : {4'h0, value_i[3:0]};
      end
      KIND_CHAR: begin
        req_o.keep = 1'b1;
        req_o.rs   = 1'b1;
      end
      KIND_CURSOR: begin
        req_o.keep = 1'b1;
        req_o.rs   = 1'b0;
        byte_w     = {1'b1, row_i, 2'b00, column_i};
      end
      default: begin
        req_o.keep = 1'b0;
      end
    endcase
    if (req_o.keep && lcdws_kind_e'(kind_i) != KIND_CMD) begin
      if (bus_is_8bit_i) begin
        req_o.bus0 = byte_w;
      end else begin
        req_o.two  = 1'b1;
        req_o.bus0 = {4'h0, byte_w[7:4]};
        req_o.bus1 = {4'h0, byte_w[3:0]};
      end
    end
  end

endmodule

[sv/lcdws_strobe.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdws_strobe
// Request register and strobe output register; splits nibble requests.
// ----------------------------------------------------------------------------
module lcdws_strobe
  import lcdws_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  lcdws_req_t in_req_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       out_rs_o,
  output logic [7:0] out_bus_o,
  output logic       out_last_o
);

  logic       req_vld_q, req_vld_d;
  lcdws_req_t req_q, req_d;
  logic       phase_q, phase_d;
  logic       out_vld_q, out_vld_d;
  logic       out_rs_q, out_rs_d;
  logic [7:0] out_bus_q, out_bus_d;
  logic       out_last_q, out_last_d;
  logic       out_free, req_final, load, in_acc;

  assign out_free   = !out_vld_q || out_ready_i;
  assign req_final  = !req_q.two || phase_q;
  assign load       = req_vld_q && out_free;
  assign in_ready_o = !req_vld_q || (out_free && req_final);
  assign in_acc     = in_valid_i && in_ready_o;

  always_comb begin
    req_vld_d  = req_vld_q;
    req_d      = req_q;
    phase_d    = phase_q;
    out_vld_d  = out_vld_q;
    out_rs_d   = out_rs_q;
    out_bus_d  = out_bus_q;
    out_last_d = out_last_q;
    if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
    if (load) begin
      out_vld_d  = 1'b1;
      out_rs_d   = req_q.rs;
      out_bus_d  = phase_q ? req_q.bus1 : req_q.bus0;
      out_last_d = req_final;
      if (req_final) begin
        req_vld_d = 1'b0;
        phase_d   = 1'b0;
      end else begin
        phase_d = 1'b1;
      end
    end
    if (in_acc) begin
      req_vld_d = in_req_i.keep;
      req_d     = in_req_i;
      phase_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_vld_q <= 1'b0;
      phase_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      req_vld_q <= req_vld_d;
      phase_q   <= phase_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    out_rs_q   <= out_rs_d;
    out_bus_q  <= out_bus_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_rs_o    = out_rs_q;
  assign out_bus_o   = out_bus_q;
  assign out_last_o  = out_last_q;

  a_phase_needs_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q |-> req_vld_q && req_q.two)
    else $error("second nibble pending without a two-strobe request");

  a_first_nibble_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && req_q.two && !phase_q |=> out_vld_q && !out_last_q)
    else $error("high nibble marked last");

  a_open_request_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_last_q |-> req_vld_q && phase_q)
    else $error("non-final strobe without its low nibble pending");

  a_accept_frees_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && req_vld_q |-> load && req_final)
    else $error("request overwritten before its last strobe");

endmodule

[sv/char_lcd_write_sequencer_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_write_sequencer_top
// Turns command, character and cursor transactions into LCD enable strobes.
//
//   channel  direction  payload                       handshake
//   req_if   in         kind, value, column, row      valid/ready
//   strb_if  out        reg_select, bus, last         valid/ready
//   cfg      in         cfg_wdata_i (bus_is_8bit)     cfg_we_i
//
// A transaction is registered, then gives one strobe per cycle from the
// output register while strb_if is ready: one strobe per request in 8-bit
// mode and for commands, two for character and cursor requests in nibble
// mode. Reset selects the 8-bit bus. A stalled output holds its strobe
// and the request register takes a new transaction once its last strobe
// moves into the output register.
// ----------------------------------------------------------------------------
module char_lcd_write_sequencer_top
  import lcdws_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic          cfg_wdata_i,
  lcdws_req_if.sink     req_if,
  lcdws_strobe_if.source strb_if
);

  logic       bus_is_8bit_q;
  lcdws_req_t dec_req;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bus_is_8bit_q <= 1'b1;
    end else if (cfg_we_i) begin
      bus_is_8bit_q <= cfg_wdata_i;
    end
  end

  lcdws_decode u_decode (
    .kind_i        (req_if.kind),
    .value_i       (req_if.value),
    .column_i      (req_if.column),
    .row_i         (req_if.row),
    .bus_is_8bit_i (bus_is_8bit_q),
    .req_o         (dec_req)
  );

  lcdws_strobe u_strobe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_if.valid),
    .in_ready_o  (req_if.ready),
    .in_req_i    (dec_req),
    .out_valid_o (strb_if.valid),
    .out_ready_i (strb_if.ready),
    .out_rs_o    (strb_if.reg_select),
    .out_bus_o   (strb_if.bus),
    .out_last_o  (strb_if.last)
  );

endmodule
